[design/psd_pkg.sv]
// types and constants shared by the stride detector table modules
`default_nettype none

package psd_pkg;

   localparam int PSD_TABLE_DEPTH = 16;
   localparam logic [1:0] MAX_CONF = 2'd3;

   typedef enum logic [1:0] {
      OP_OBSERVE   = 2'd0,
      OP_SET_TERM  = 2'd1,
      OP_READ_TERM = 2'd2,
      OP_CLEAR     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_UPDATE
   } state_type;

   // classified request as it sits in the queue
   typedef struct packed {
      op_type      op;
      logic        needs_scan;
      logic [63:0] pc;
      logic [63:0] address;
      logic [63:0] terminator;
   } cmd_type;

   // one table entry as held in the entry memory
   typedef struct packed {
      logic [63:0] pc;
      logic [63:0] last_address;
      logic [63:0] stride;
      logic [1:0]  confidence;
      logic [63:0] age;
      logic [63:0] terminator;
   } entry_type;

   typedef struct packed {
      logic               candidate_valid;
      logic [63:0]        candidate_pc;
      logic [63:0]        candidate_address;
      logic signed [63:0] candidate_stride;
      logic [63:0]        terminator_out;
   } rsp_type;

endpackage

`default_nettype wire

[design/psd_req_if.sv]
// request channel interface
`default_nettype none

interface psd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [63:0] pc;
   logic [63:0] address;
   logic [63:0] terminator_in;

   modport source (output valid, op, pc, address, terminator_in, input ready);
   modport sink (input valid, op, pc, address, terminator_in, output ready);
endinterface

`default_nettype wire

[design/psd_rsp_if.sv]
// response channel interface
`default_nettype none

interface psd_rsp_if;
   logic               valid;
   logic               ready;
   logic               candidate_valid;
   logic [63:0]        candidate_pc;
   logic [63:0]        candidate_address;
   logic signed [63:0] candidate_stride;
   logic [63:0]        terminator_out;

   modport source (output valid, candidate_valid, candidate_pc, candidate_address,
                   candidate_stride, terminator_out, input ready);
   modport sink (input valid, candidate_valid, candidate_pc, candidate_address,
                 candidate_stride, terminator_out, output ready);
endinterface

`default_nettype wire

[design/psd_front.sv]
// request intake: decodes each request and holds it in a two-entry queue
`default_nettype none

module psd_front
   import psd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   psd_req_if.sink req_chan,
   output logic    q_valid,
   output cmd_type q_cmd,
   input  logic    q_pop
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    cmd;
   logic       push, pop;

   always_comb begin
      cmd.op         = op_type'(req_chan.op);
      cmd.needs_scan = (op_type'(req_chan.op) != OP_CLEAR);
      cmd.pc         = req_chan.pc;
      cmd.address    = req_chan.address;
      cmd.terminator = req_chan.terminator_in;
   end

   assign req_chan.ready = (count_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign q_valid        = (count_ff != 2'd0);
   assign pop            = q_pop && q_valid;
   assign q_cmd          = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

`default_nettype wire

[design/psd_back.sv]
// table engine: scans the entry memory, updates the entry and drives the response
`default_nettype none

module psd_back
   import psd_pkg::*;
#(
   parameter int TABLE_DEPTH = PSD_TABLE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  cmd_type   q_cmd,
   output logic      q_pop,
   psd_rsp_if.source rsp_chan
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   entry_type entry_mem [TABLE_DEPTH];

   state_type              state_ff, state_in;
   cmd_type                cur_ff, cur_in;
   entry_type              rd_rec_ff;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic                   hit_ff, hit_in;
   logic                   inv_ff, inv_in;
   logic [IDX_W-1:0]       inv_idx_ff, inv_idx_in;
   logic                   best_ok_ff, best_ok_in;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   logic [63:0]            best_age_ff, best_age_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [63:0]            clock_ff, clock_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_ff, out_in;

   logic             out_free;
   logic [IDX_W-1:0] cur_idx;
   logic [CNT_W-1:0] idx_next;
   logic             rd_en;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   entry_type        wr_rec;
   logic [63:0]      seen;
   logic [1:0]       conf_dn, conf_new;
   logic [63:0]      stride_new;
   logic [63:0]      clock_inc;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign cur_idx  = idx_ff[IDX_W-1:0];
   assign idx_next = idx_ff + 1'b1;
   assign clock_inc = clock_ff + 64'd1;

   // stride training for an observe hit
   always_comb begin
      seen    = cur_ff.address - rd_rec_ff.last_address;
      conf_dn = (rd_rec_ff.confidence != 2'd0) ? rd_rec_ff.confidence - 2'd1 : 2'd0;
      if (seen != 64'd0 && seen == rd_rec_ff.stride) begin
         conf_new   = (rd_rec_ff.confidence < MAX_CONF) ? rd_rec_ff.confidence + 2'd1
                                                        : rd_rec_ff.confidence;
         stride_new = rd_rec_ff.stride;
      end else begin
         conf_new   = conf_dn;
         stride_new = (conf_dn == 2'd0) ? seen : rd_rec_ff.stride;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      inv_in       = inv_ff;
      inv_idx_in   = inv_idx_ff;
      best_ok_in   = best_ok_ff;
      best_idx_in  = best_idx_ff;
      best_age_in  = best_age_ff;
      valid_in     = valid_ff;
      clock_in     = clock_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      q_pop        = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_idx       = hit_ff ? cur_idx : (inv_ff ? inv_idx_ff : best_idx_ff);
      wr_rec       = rd_rec_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && (q_cmd.needs_scan || out_free)) begin
               q_pop  = 1'b1;
               cur_in = q_cmd;
               if (!q_cmd.needs_scan) begin
                  // clear the whole table at once
                  valid_in     = '0;
                  clock_in     = 64'd0;
                  out_in       = '0;
                  out_valid_in = 1'b1;
               end else begin
                  idx_in     = '0;
                  hit_in     = 1'b0;
                  inv_in     = 1'b0;
                  best_ok_in = 1'b0;
                  state_in   = ST_READ;
               end
            end
         end

         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_CHECK;
         end

         ST_CHECK: begin
            if (valid_ff[cur_idx] && rd_rec_ff.pc == cur_ff.pc) begin
               hit_in   = 1'b1;
               state_in = ST_UPDATE;
            end else begin
               if (!valid_ff[cur_idx]) begin
                  if (!inv_ff) begin
                     inv_in     = 1'b1;
                     inv_idx_in = cur_idx;
                  end
               end else if (!best_ok_ff || rd_rec_ff.age < best_age_ff) begin
                  best_ok_in  = 1'b1;
                  best_idx_in = cur_idx;
                  best_age_in = rd_rec_ff.age;
               end
               idx_in   = idx_next;
               state_in = (idx_next == CNT_W'(TABLE_DEPTH)) ? ST_UPDATE : ST_READ;
            end
         end

         ST_UPDATE: begin
            if (out_free) begin
               out_in       = '0;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
               case (cur_ff.op)
                  OP_OBSERVE: begin
                     clock_in = clock_inc;
                     wr_en    = 1'b1;
                     if (hit_ff) begin
                        wr_rec.last_address = cur_ff.address;
                        wr_rec.stride       = stride_new;
                        wr_rec.confidence   = conf_new;
                        wr_rec.age          = clock_inc;
                        if (stride_new != 64'd0 && conf_new == MAX_CONF) begin
                           out_in.candidate_valid   = 1'b1;
                           out_in.candidate_pc      = cur_ff.pc;
                           out_in.candidate_address = cur_ff.address;
                           out_in.candidate_stride  = stride_new;
                        end
                     end else begin
                        wr_rec.pc           = cur_ff.pc;
                        wr_rec.last_address = cur_ff.address;
                        wr_rec.stride       = 64'd0;
                        wr_rec.confidence   = 2'd0;
                        wr_rec.age          = clock_inc;
                        wr_rec.terminator   = 64'd0;
                        valid_in[wr_idx]    = 1'b1;
                     end
                  end
                  OP_SET_TERM: begin
                     if (hit_ff) begin
                        wr_en             = 1'b1;
                        wr_rec.terminator = cur_ff.terminator;
                     end
                  end
                  OP_READ_TERM: begin
                     if (hit_ff) begin
                        out_in.terminator_out = rd_rec_ff.terminator;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         hit_ff       <= 1'b0;
         inv_ff       <= 1'b0;
         best_ok_ff   <= 1'b0;
         valid_ff     <= '0;
         clock_ff     <= 64'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         hit_ff       <= hit_in;
         inv_ff       <= inv_in;
         best_ok_ff   <= best_ok_in;
         valid_ff     <= valid_in;
         clock_ff     <= clock_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      inv_idx_ff  <= inv_idx_in;
      best_idx_ff <= best_idx_in;
      best_age_ff <= best_age_in;
      out_ff      <= out_in;
   end

   // entry memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_idx] <= wr_rec;
      end
      if (rd_en) begin
         rd_rec_ff <= entry_mem[cur_idx];
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.candidate_valid   = out_ff.candidate_valid;
   assign rsp_chan.candidate_pc      = out_ff.candidate_pc;
   assign rsp_chan.candidate_address = out_ff.candidate_address;
   assign rsp_chan.candidate_stride  = out_ff.candidate_stride;
   assign rsp_chan.terminator_out    = out_ff.terminator_out;

endmodule

`default_nettype wire

[design/pc_stride_detector_table_top.sv]
// pc-keyed stride detector table: request queue in front, table engine behind
//
// req_chan carries one request per valid/ready handshake: op selects observe,
// set terminator, read terminator or clear. rsp_chan returns exactly one
// response per request, in order, from an output register.
// Requests land in a two-entry queue, so up to two more are taken while the
// engine works or while a response waits for rsp_chan.ready.
// The engine walks the entry memory through its single read port, reading
// each entry in ST_READ and comparing it in ST_CHECK, stopping at the first
// matching pc. A miss walks all TABLE_DEPTH entries (the allocation victim
// needs the full walk); clear skips the walk. The response is visible the
// cycle after the engine finishes. The engine takes no new request until it
// has finished the last one.
// Reset (synchronous, active high) empties the queue, drops any response,
// marks every entry invalid and zeroes the access clock; no memory sweep is
// needed since invalid entries are never read as data.
// When rsp_chan stalls, the engine holds its finished request until the
// output register frees, and the queue keeps accepting until full.
`default_nettype none

module pc_stride_detector_table_top
   import psd_pkg::*;
#(
   parameter int TABLE_DEPTH = PSD_TABLE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   psd_req_if.sink   req_chan,
   psd_rsp_if.source rsp_chan
);

   logic    q_valid;
   cmd_type q_cmd;
   logic    q_pop;

   psd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd),
      .q_pop    (q_pop)
   );

   psd_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

[dv/pc_stride_detector_table_top_tb.sv]
// self-checking testbench for the pc-keyed stride detector table
`timescale 1ns / 1ps

module pc_stride_detector_table_top_tb;
   import psd_pkg::*;

   localparam int TABLE_DEPTH  = PSD_TABLE_DEPTH;
   localparam int RANDOM_ITEMS = 950;
   localparam int PC_POOL      = 20;
   localparam int PHASE_ONE    = 320;
   localparam int PHASE_TWO    = 640;
   localparam int DRAIN_AT     = 500;
   localparam int HOLD_AT      = 700;
   localparam int HOLD_LEN     = 400;
   localparam int SETTLE       = 2 * TABLE_DEPTH + 8;

   typedef struct packed {
      op_type      op;
      logic [63:0] pc;
      logic [63:0] address;
      logic [63:0] terminator;
   } table_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   psd_req_if req_chan();
   psd_rsp_if rsp_chan();

   pc_stride_detector_table_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   // predictor copy of the table
   logic        tbl_valid  [TABLE_DEPTH];
   logic [63:0] tbl_pc     [TABLE_DEPTH];
   logic [63:0] tbl_last   [TABLE_DEPTH];
   logic [63:0] tbl_stride [TABLE_DEPTH];
   logic [1:0]  tbl_conf   [TABLE_DEPTH];
   logic [63:0] tbl_age    [TABLE_DEPTH];
   logic [63:0] tbl_term   [TABLE_DEPTH];
   logic [63:0] tbl_tick;

   table_req_type pending_reqs[$];
   rsp_type       stride_expect_q[$];
   table_req_type cur_req;

   int sent_count = 0;
   int req_count = 0;
   int rsp_count = 0;
   int in_flight = 0;
   int error_count = 0;
   int candidate_count = 0;
   int eviction_count = 0;
   int clear_count = 0;
   int hold_cycles = 0;
   logic drain_armed = 1'b0;

   logic [63:0] pool_pc   [PC_POOL];
   logic [63:0] pool_next [PC_POOL];
   logic [63:0] pool_step [PC_POOL];

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pick_step();
      logic [63:0] s;
      if ($urandom_range(3) == 0) begin
         s = rand64();
      end else begin
         s = 64'($urandom_range(64, 1)) << $urandom_range(6, 0);
         if ($urandom_range(1) == 1) begin
            s = -s;
         end
      end
      return s;
   endfunction

   function automatic void clear_stride_table();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         tbl_valid[i]  = 1'b0;
         tbl_pc[i]     = '0;
         tbl_last[i]   = '0;
         tbl_stride[i] = '0;
         tbl_conf[i]   = '0;
         tbl_age[i]    = '0;
         tbl_term[i]   = '0;
      end
      tbl_tick = '0;
   endfunction

   function automatic int lookup_pc(logic [63:0] pc);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (tbl_valid[i] && tbl_pc[i] == pc) begin
            return i;
         end
      end
      return -1;
   endfunction

   function automatic rsp_type predict_stride_table(op_type op, logic [63:0] pc,
                                                    logic [63:0] addr, logic [63:0] term);
      rsp_type     res;
      int          e;
      logic [63:0] seen;
      res = '0;
      e = lookup_pc(pc);
      case (op)
         OP_OBSERVE: begin
            tbl_tick = tbl_tick + 64'd1;
            if (e < 0) begin
               // first free slot, else the least recently touched one
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (!tbl_valid[i]) begin
                     e = i;
                     break;
                  end
               end
               if (e < 0) begin
                  e = 0;
                  for (int i = 1; i < TABLE_DEPTH; i++) begin
                     if (tbl_age[i] < tbl_age[e]) begin
                        e = i;
                     end
                  end
                  eviction_count++;
               end
               tbl_valid[e]  = 1'b1;
               tbl_pc[e]     = pc;
               tbl_last[e]   = addr;
               tbl_stride[e] = '0;
               tbl_conf[e]   = '0;
               tbl_age[e]    = tbl_tick;
               tbl_term[e]   = '0;
            end else begin
               seen = addr - tbl_last[e];
               if (seen != '0 && seen == tbl_stride[e]) begin
                  if (tbl_conf[e] < MAX_CONF) begin
                     tbl_conf[e] = tbl_conf[e] + 2'd1;
                  end
               end else begin
                  if (tbl_conf[e] != 2'd0) begin
                     tbl_conf[e] = tbl_conf[e] - 2'd1;
                  end
                  if (tbl_conf[e] == 2'd0) begin
                     tbl_stride[e] = seen;
                  end
               end
               tbl_last[e] = addr;
               tbl_age[e]  = tbl_tick;
               if (tbl_stride[e] != '0 && tbl_conf[e] == MAX_CONF) begin
                  res.candidate_valid   = 1'b1;
                  res.candidate_pc      = pc;
                  res.candidate_address = addr;
                  res.candidate_stride  = tbl_stride[e];
               end
            end
         end
         OP_SET_TERM: begin
            if (e >= 0) begin
               tbl_term[e] = term;
            end
         end
         OP_READ_TERM: begin
            if (e >= 0) begin
               res.terminator_out = tbl_term[e];
            end
         end
         default: begin
            clear_stride_table();
            clear_count++;
         end
      endcase
      return res;
   endfunction

   task automatic push_req(op_type op, logic [63:0] pc, logic [63:0] addr,
                           logic [63:0] term);
      table_req_type r;
      r.op         = op;
      r.pc         = pc;
      r.address    = addr;
      r.terminator = term;
      pending_reqs.push_back(r);
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= 10) begin
            $display("response %0d: %s expected %h, got %h", rsp_count, name, want, got);
         end
      end
   endtask

   function automatic int sender_idle_pct();
      if (req_count < PHASE_ONE) begin
         return 24;
      end else if (req_count < PHASE_TWO) begin
         return 85;
      end
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (req_count < PHASE_ONE) begin
         return 85;
      end else if (req_count < PHASE_TWO) begin
         return 24;
      end
      return 0;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            sent_count++;
         end
         // pause once until the block has answered everything
         if (req_chan.valid && req_chan.ready && sent_count == DRAIN_AT) begin
            drain_armed = 1'b1;
         end else if (drain_armed && in_flight == 0) begin
            drain_armed = 1'b0;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_reqs.size() != 0 && !drain_armed &&
                $urandom_range(99) >= sender_idle_pct()) begin
               cur_req = pending_reqs.pop_front();
               req_chan.valid         <= 1'b1;
               req_chan.op            <= cur_req.op;
               req_chan.pc            <= cur_req.pc;
               req_chan.address       <= cur_req.address;
               req_chan.terminator_in <= cur_req.terminator;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // receiver, with one long hold-off so the request queue fills up
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (req_count >= HOLD_AT && hold_cycles < HOLD_LEN) begin
         hold_cycles++;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= receiver_idle_pct());
      end
   end

   // monitor: predicts on each accepted request, checks each accepted response
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_stride_table();
         in_flight <= 0;
         req_count <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            stride_expect_q.push_back(predict_stride_table(op_type'(req_chan.op), req_chan.pc,
                                                           req_chan.address,
                                                           req_chan.terminator_in));
            req_count <= req_count + 1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (stride_expect_q.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("response %0d arrived with no request outstanding", rsp_count);
               end
            end else begin
               want = stride_expect_q.pop_front();
               check_field("candidate_valid", 64'(want.candidate_valid),
                           64'(rsp_chan.candidate_valid));
               check_field("candidate_pc", want.candidate_pc, rsp_chan.candidate_pc);
               check_field("candidate_address", want.candidate_address,
                           rsp_chan.candidate_address);
               check_field("candidate_stride", want.candidate_stride,
                           rsp_chan.candidate_stride);
               check_field("terminator_out", want.terminator_out, rsp_chan.terminator_out);
               if (want.candidate_valid) begin
                  candidate_count++;
               end
            end
            rsp_count++;
         end
         in_flight <= in_flight + int'(req_chan.valid && req_chan.ready)
                                - int'(rsp_chan.valid && rsp_chan.ready);
      end
   end

   initial begin
      int          directed_n;
      int          idx;
      int          len;
      int          pick;
      logic [63:0] addr;

      req_chan.valid         = 1'b0;
      req_chan.op            = OP_OBSERVE;
      req_chan.pc            = '0;
      req_chan.address       = '0;
      req_chan.terminator_in = '0;
      rsp_chan.ready         = 1'b0;

      // empty table: lookups miss
      push_req(OP_READ_TERM, '0, '0, '0);
      push_req(OP_SET_TERM, '0, '0, '1);
      push_req(OP_READ_TERM, '0, '0, '0);
      // descending stream at the top pc, address wrapping through zero
      push_req(OP_OBSERVE, '1, '0, '0);
      for (int k = 1; k <= 5; k++) begin
         push_req(OP_OBSERVE, '1, -64'(k), '0);
      end
      // repeated address breaks the run
      push_req(OP_OBSERVE, '1, -64'(5), '0);
      push_req(OP_SET_TERM, '1, '0, 64'ha5a5_5a5a_ffff_0001);
      push_req(OP_READ_TERM, '1, '0, '0);
      // stride at the sign boundary
      push_req(OP_OBSERVE, '0, 64'h8000_0000_0000_0000, '0);
      push_req(OP_OBSERVE, '0, '0, '0);
      push_req(OP_OBSERVE, '0, 64'h8000_0000_0000_0000, '0);
      push_req(OP_CLEAR, rand64(), rand64(), rand64());
      push_req(OP_READ_TERM, '1, '0, '0);
      push_req(OP_OBSERVE, '1, 64'h7fff_ffff_ffff_ffff, '0);
      push_req(OP_OBSERVE, 64'h0123_4567_89ab_cdef, '1, '0);
      push_req(OP_READ_TERM, 64'h0123_4567_89ab_cdef, '0, '0);
      directed_n = pending_reqs.size();

      for (int i = 0; i < PC_POOL; i++) begin
         pool_pc[i]   = rand64();
         pool_next[i] = rand64();
         pool_step[i] = pick_step();
      end
      pool_pc[0] = '0;
      pool_pc[1] = '1;

      // mostly bursts of strided loads per pc; more pcs than entries forces evictions
      while (pending_reqs.size() < directed_n + RANDOM_ITEMS) begin
         pick = $urandom_range(99);
         idx  = $urandom_range(PC_POOL - 1);
         if (pick < 75) begin
            len = $urandom_range(7, 1);
            for (int k = 0; k < len; k++) begin
               case ($urandom_range(19))
                  0: addr = rand64();
                  1: addr = pool_next[idx] - pool_step[idx];
                  2: begin
                     pool_step[idx] = pick_step();
                     addr = pool_next[idx];
                  end
                  default: addr = pool_next[idx];
               endcase
               push_req(OP_OBSERVE, pool_pc[idx], addr, rand64());
               pool_next[idx] = addr + pool_step[idx];
            end
         end else if (pick < 85) begin
            push_req(OP_SET_TERM, ($urandom_range(7) == 0) ? rand64() : pool_pc[idx],
                     rand64(), rand64());
         end else if (pick < 96) begin
            push_req(OP_READ_TERM, ($urandom_range(7) == 0) ? rand64() : pool_pc[idx],
                     rand64(), rand64());
         end else if (pick < 98) begin
            push_req(OP_CLEAR, rand64(), rand64(), rand64());
         end else begin
            push_req(OP_OBSERVE, rand64(), rand64(), rand64());
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_chan.valid) begin
         @(posedge clock);
      end
      while (in_flight != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);

      if (stride_expect_q.size() != 0) begin
         error_count += stride_expect_q.size();
         $display("%0d responses never arrived", stride_expect_q.size());
      end
      $display("covered %0d requests and %0d responses: %0d stride candidates,",
               req_count, rsp_count, candidate_count);
      $display("%0d table evictions, %0d clears, %0d errors",
               eviction_count, clear_count, error_count);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d responses outstanding", in_flight);
      $display("Some tests failed");
      $finish;
   end

endmodule
